>>> design/dynamic_priority_slice_scheduler_top_macros.svh
// Assertion macros shared by the scheduler RTL.
`ifndef DYNAMIC_PRIORITY_SLICE_SCHEDULER_TOP_MACROS_SVH
`define DYNAMIC_PRIORITY_SLICE_SCHEDULER_TOP_MACROS_SVH
`ifndef SYNTH
`define DPSS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define DPSS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define DPSS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define DPSS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> design/dpss_pkg.sv
// Types and constants shared by the scheduler controller, datapath and top level.
`default_nettype none
package dpss_pkg;

	localparam int TABLE_DEPTH_DEF = 8;
	localparam logic [7:0] QUANTUM_RESET = 8'd3;
	localparam logic signed [15:0] FINISHED_PRIORITY = -16'sd1000;
	localparam logic signed [15:0] PRIORITY_MIN = -16'sd32768;

	// One row of the job table.
	typedef struct packed {
		logic [15:0] prio;
		logic [11:0] rem;
		logic [11:0] worked;
		logic [11:0] total;
		logic [15:0] arrival;
	} dpss_entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic add;
		logic scan_issue;
		logic update;
		logic emit;
	} dpss_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic count_zero;
		logic scan_last;
	} dpss_sts_t;

endpackage
`default_nettype wire

>>> design/dpss_datapath.sv
// Job table, scan compare unit, job update arithmetic and result registers.
`default_nettype none
module dpss_datapath #(
	parameter int TABLE_DEPTH = dpss_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire dpss_pkg::dpss_cmd_t cmd,
	output dpss_pkg::dpss_sts_t      sts,
	input  wire logic                cfg_we,
	input  wire logic [7:0]          cfg_wdata,
	input  wire logic signed [9:0]   priority_req,
	input  wire logic [11:0]         need_time,
	input  wire logic [15:0]         arrival_time,
	output logic                     done,
	output logic [2:0]               slot,
	output logic signed [15:0]       priority_now,
	output logic [11:0]              remaining,
	output logic [11:0]              worked,
	output logic                     finished,
	output logic                     idle,
	output logic                     all_done,
	output logic                     table_full,
	output logic [15:0]              now_time
);
	import dpss_pkg::*;

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	logic [7:0]             quantum_q;
	logic [15:0]            clock_q;
	logic [CNT_W-1:0]       count_q;
	logic [IDX_W-1:0]       scan_idx_q;
	logic [15:0]            in_prio_q;
	logic [11:0]            in_need_q;
	logic [15:0]            in_arr_q;
	dpss_entry_t            mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] done_q;
	dpss_entry_t            rd_entry_s1;
	logic                   rd_done_s1;
	logic [IDX_W-1:0]       rd_idx_s1;
	logic                   rd_vld_s1;
	logic                   best_found_q;
	logic [IDX_W-1:0]       best_idx_q;
	dpss_entry_t            best_entry_q;
	logic [2:0]             res_slot_q;
	logic [15:0]            res_prio_q;
	logic [11:0]            res_rem_q;
	logic [11:0]            res_worked_q;
	logic                   res_fin_q;
	logic                   res_idle_q;
	logic                   res_full_q;
	logic                   done_strobe_q;

	logic                   full;
	logic [IDX_W-1:0]       add_idx;
	logic                   elig_s1;
	logic                   better_s1;
	logic                   take_s1;
	logic [11:0]            q12;
	logic [15:0]            dec_prio;
	logic                   fin;
	dpss_entry_t            upd_entry;
	dpss_entry_t            add_entry;
	logic                   wr_en;
	logic [IDX_W-1:0]       wr_addr;
	dpss_entry_t            wr_data;
	logic                   all_done_c;

	assign full    = (count_q >= CNT_W'(TABLE_DEPTH));
	assign add_idx = count_q[IDX_W-1:0];

	assign sts.count_zero = (count_q == '0);
	assign sts.scan_last  = ((CNT_W'(scan_idx_q) + CNT_W'(1)) == count_q);

	// A read entry competes when it has arrived and is not finished.
	assign elig_s1   = rd_vld_s1 && !rd_done_s1 && (rd_entry_s1.arrival <= clock_q);
	assign better_s1 = !best_found_q
		|| ($signed(rd_entry_s1.prio) > $signed(best_entry_q.prio))
		|| (($signed(rd_entry_s1.prio) == $signed(best_entry_q.prio))
			&& (rd_entry_s1.arrival < best_entry_q.arrival));
	assign take_s1   = elig_s1 && better_s1;

	assign q12      = {4'd0, quantum_q};
	assign dec_prio = ($signed(best_entry_q.prio) > PRIORITY_MIN) ?
		best_entry_q.prio - 16'd1 : best_entry_q.prio;
	assign fin      = (best_entry_q.rem <= q12);

	always_comb begin
		upd_entry         = best_entry_q;
		upd_entry.prio    = fin ? FINISHED_PRIORITY : dec_prio;
		upd_entry.rem     = fin ? 12'd0 : best_entry_q.rem - q12;
		upd_entry.worked  = fin ? best_entry_q.total : best_entry_q.worked + q12;
		add_entry.prio    = in_prio_q;
		add_entry.rem     = in_need_q;
		add_entry.worked  = 12'd0;
		add_entry.total   = in_need_q;
		add_entry.arrival = in_arr_q;
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = best_idx_q;
		wr_data = upd_entry;
		if (cmd.add && !full) begin
			wr_en   = 1'b1;
			wr_addr = add_idx;
			wr_data = add_entry;
		end else if (cmd.update && best_found_q) begin
			wr_en = 1'b1;
		end
	end

	always_comb begin
		all_done_c = 1'b1;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if ((CNT_W'(i) < count_q) && !done_q[i])
				all_done_c = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q     <= QUANTUM_RESET;
			clock_q       <= 16'd0;
			count_q       <= '0;
			scan_idx_q    <= '0;
			rd_vld_s1     <= 1'b0;
			best_found_q  <= 1'b0;
			done_strobe_q <= 1'b0;
		end else begin
			if (cfg_we)
				quantum_q <= cfg_wdata;
			if (cmd.load) begin
				scan_idx_q   <= '0;
				best_found_q <= 1'b0;
			end else begin
				if (cmd.scan_issue)
					scan_idx_q <= scan_idx_q + IDX_W'(1);
				if (take_s1)
					best_found_q <= 1'b1;
			end
			rd_vld_s1 <= cmd.scan_issue;
			if (cmd.add && !full)
				count_q <= count_q + CNT_W'(1);
			if (cmd.update)
				clock_q <= clock_q + {8'd0, quantum_q};
			done_strobe_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (cmd.scan_issue)
			rd_entry_s1 <= mem[scan_idx_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_prio_q <= 16'($signed(priority_req));
			in_need_q <= need_time;
			in_arr_q  <= arrival_time;
		end
		if (cmd.scan_issue) begin
			rd_done_s1 <= done_q[scan_idx_q];
			rd_idx_s1  <= scan_idx_q;
		end
		if (take_s1) begin
			best_idx_q   <= rd_idx_s1;
			best_entry_q <= rd_entry_s1;
		end
		if (cmd.add) begin
			res_idle_q <= 1'b0;
			res_fin_q  <= 1'b0;
			if (full) begin
				res_slot_q   <= 3'd0;
				res_prio_q   <= 16'd0;
				res_rem_q    <= 12'd0;
				res_worked_q <= 12'd0;
				res_full_q   <= 1'b1;
			end else begin
				done_q[add_idx] <= 1'b0;
				res_slot_q      <= 3'(add_idx);
				res_prio_q      <= add_entry.prio;
				res_rem_q       <= add_entry.rem;
				res_worked_q    <= 12'd0;
				res_full_q      <= 1'b0;
			end
		end
		if (cmd.update) begin
			res_full_q <= 1'b0;
			if (best_found_q) begin
				done_q[best_idx_q] <= fin;
				res_slot_q         <= 3'(best_idx_q);
				res_prio_q         <= upd_entry.prio;
				res_rem_q          <= upd_entry.rem;
				res_worked_q       <= upd_entry.worked;
				res_fin_q          <= fin;
				res_idle_q         <= 1'b0;
			end else begin
				res_slot_q   <= 3'd0;
				res_prio_q   <= 16'd0;
				res_rem_q    <= 12'd0;
				res_worked_q <= 12'd0;
				res_fin_q    <= 1'b0;
				res_idle_q   <= 1'b1;
			end
		end
		if (cmd.emit) begin
			slot         <= res_slot_q;
			priority_now <= res_prio_q;
			remaining    <= res_rem_q;
			worked       <= res_worked_q;
			finished     <= res_fin_q;
			idle         <= res_idle_q;
			table_full   <= res_full_q;
			all_done     <= all_done_c;
			now_time     <= clock_q;
		end
	end

	assign done = done_strobe_q;

endmodule
`default_nettype wire

>>> design/dpss_ctrl.sv
// Sequencing state machine of the scheduler.
`default_nettype none
module dpss_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic                req_type,
	input  wire dpss_pkg::dpss_sts_t sts,
	output dpss_pkg::dpss_cmd_t      cmd,
	output logic                     busy
);
	import dpss_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_ADD    = 6'b000010,
		S_SCAN   = 6'b000100,
		S_DRAIN  = 6'b001000,
		S_UPDATE = 6'b010000,
		S_EMIT   = 6'b100000
	} dpss_state_t;

	dpss_state_t state_q;
	dpss_state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (!req_type)
						state_d = S_ADD;
					else if (sts.count_zero)
						state_d = S_UPDATE;
					else
						state_d = S_SCAN;
				end
			end
			S_ADD: begin
				cmd.add = 1'b1;
				state_d = S_EMIT;
			end
			S_SCAN: begin
				cmd.scan_issue = 1'b1;
				if (sts.scan_last)
					state_d = S_DRAIN;
			end
			S_DRAIN: begin
				state_d = S_UPDATE;
			end
			S_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = S_EMIT;
			end
			S_EMIT: begin
				cmd.emit = 1'b1;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	assign busy = (state_q != S_IDLE);

endmodule
`default_nettype wire

>>> design/dynamic_priority_slice_scheduler_top.sv
// Top level of the dynamic priority slice scheduler with aging.
`default_nettype none
`include "dynamic_priority_slice_scheduler_top_macros.svh"
// The block keeps a table of up to TABLE_DEPTH jobs and takes one item at a time: an item
// is accepted at a rising edge where start is high and busy is low, and req_type picks
// between adding a job (0) and running one time slice (1). Exactly one result follows each
// item, shown on the result ports for a single cycle while done is high; the receiver cannot
// stall it, so it must capture the result in that cycle. An add passes through the add and
// emit states. A run passes through the scan, drain, update and emit states when N jobs are
// stored (N > 0), and only through update and emit on an empty table: the datapath reads
// the single-port job table one entry per cycle and compares each against the best candidate
// so far, then writes the chosen job back.
// Busy falls in the cycle where done is high, so the next item may be accepted right then.
// The quantum register (reset value 3) is written through cfg_we and cfg_wdata, and should
// only be changed while busy is low and no result is pending.
module dynamic_priority_slice_scheduler_top #(
	parameter int TABLE_DEPTH = dpss_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	output logic                   done,
	input  wire logic              cfg_we,
	input  wire logic [7:0]        cfg_wdata,
	input  wire logic              req_type,
	input  wire logic signed [9:0] priority_req,
	input  wire logic [11:0]       need_time,
	input  wire logic [15:0]       arrival_time,
	output logic [2:0]             slot,
	output logic signed [15:0]     priority_now,
	output logic [11:0]            remaining,
	output logic [11:0]            worked,
	output logic                   finished,
	output logic                   idle,
	output logic                   all_done,
	output logic                   table_full,
	output logic [15:0]            now_time
);
	import dpss_pkg::*;

	// Command and status bundles between the sequencer and the datapath.
	dpss_cmd_t cmd;
	dpss_sts_t sts;

	// The controller walks each item through load, then either add or optional scan and update, then result.
	dpss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.sts      (sts),
		.cmd      (cmd),
		.busy     (busy)
	);

	// The datapath holds the job table, the scheduler clock and the result registers.
	dpss_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.priority_req (priority_req),
		.need_time    (need_time),
		.arrival_time (arrival_time),
		.done         (done),
		.slot         (slot),
		.priority_now (priority_now),
		.remaining    (remaining),
		.worked       (worked),
		.finished     (finished),
		.idle         (idle),
		.all_done     (all_done),
		.table_full   (table_full),
		.now_time     (now_time)
	);

	// An accepted item keeps the block busy until its result is shown.
	`DPSS_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy, "item accepted but not busy")
	// A result cannot be an idle slice and a refused add at once.
	`DPSS_ASSERT_IMP(a_idle_full_excl, clk, arst_n, done, !(idle && table_full), "idle with full")
	// A finished job has no work left.
	`DPSS_ASSERT_IMP(a_fin_rem_zero, clk, arst_n, done && finished, remaining == 12'd0,
		"finished job with work left")
	// An idle slice reports no job.
	`DPSS_ASSERT_IMP(a_idle_clean, clk, arst_n, done && idle,
		!finished && (slot == 3'd0) && (worked == 12'd0), "idle slice reports a job")

endmodule
`default_nettype wire
